// ===== rtl/core/vector_wavetable_adsr_oscillator_macros.svh =====
// Assertion macros shared by the oscillator RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef VECTOR_WAVETABLE_ADSR_OSCILLATOR_MACROS_SVH
`define VECTOR_WAVETABLE_ADSR_OSCILLATOR_MACROS_SVH
`ifndef SYNTH
`define VWAO_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vwao assertion failed");
`define VWAO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vwao assertion failed");
`else
`define VWAO_ASSERT(label, clk, rst, prop)
`define VWAO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/vwao_pkg.sv =====
// Package for the vector wavetable oscillator: widths, defaults and register indexes.
// Used by the top level; depends on nothing.
`default_nettype none
package vwao_pkg;
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int FREQ_W = 24;
   localparam int LEVEL_W = 16;
   localparam int TIME_W = 24;
   localparam int COORD_W = 16;
   localparam int VIDX_W = 10;
   localparam int RATE_W = 17;
   localparam int SR_W = 18;
   localparam int LEN_CFG_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam int MUL_W = 26;
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 33;
   localparam int DIV_CNT_W = 6;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;
   localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;
   localparam logic [RATE_W-1:0] RATE_RESET = 17'd65562;
   localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
   localparam logic [LEN_CFG_W-1:0] LEN_RESET = 11'd1024;
   localparam logic [CSR_IDX_W-1:0] CSR_GLIDE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLIDE_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_LENGTH = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/vwao_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module vwao_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/vector_wavetable_adsr_oscillator.sv =====
// Top level of the vector wavetable oscillator with glide and envelope.
// Depends on vwao_pkg, vwao_ram and the assertion macro header.
//
// A request with mode 0 writes one vertex into the image RAM and gives no
// result. A request with mode 1 computes one output point: the frequency
// glides toward the target, the point is interpolated between two vertices
// at the current phase, scaled by the envelope, and the phase moves on.
// The work runs on one shared multiplier and one restoring divider that makes
// one quotient bit per cycle. A new request can be taken in the same cycle
// that the result is made valid. req_ready is high only while no sample is
// in progress. The result waits in an output register; if the receiver stalls,
// a new request may still be taken, and a finished sample holds the sequencer
// until the output register is free. Reset clears the phase, frequency and
// envelope state and restores the register defaults; the vertex RAM is not
// cleared. The configuration port is always ready.
`default_nettype none
`include "vector_wavetable_adsr_oscillator_macros.svh"
module vector_wavetable_adsr_oscillator #(
   parameter int MAX_VERTICES = vwao_pkg::MAX_VERTICES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic [vwao_pkg::VIDX_W-1:0]             req_vertex_index,
   input  logic signed [vwao_pkg::COORD_W-1:0]     req_vertex_x,
   input  logic signed [vwao_pkg::COORD_W-1:0]     req_vertex_y,
   input  logic [vwao_pkg::FREQ_W-1:0]             req_target_freq,
   input  logic [vwao_pkg::TIME_W-1:0]             req_attack_len,
   input  logic [vwao_pkg::TIME_W-1:0]             req_decay_len,
   input  logic [vwao_pkg::LEVEL_W-1:0]            req_sustain_level,
   input  logic [vwao_pkg::LEVEL_W-1:0]            req_peak_level,
   input  logic                                    req_segment_start,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [vwao_pkg::COORD_W-1:0]     rsp_out_x,
   output logic signed [vwao_pkg::COORD_W-1:0]     rsp_out_y,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [vwao_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vwao_pkg::CSR_DATA_W-1:0]         csr_data
);
   import vwao_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int LW = $clog2(MAX_VERTICES + 1);
   localparam int PW = AW + 16;

   typedef enum logic [4:0] {
      S_IDLE, S_ENDLVL, S_GLIDE, S_GUP, S_GDN, S_STEPMUL, S_STEPDIV, S_STEPMOD,
      S_PHMOD, S_RD0, S_RD1, S_RD2, S_ENV, S_ENVDIV, S_ENVEND, S_IX0, S_IX1,
      S_IX2, S_IY1, S_IY2, S_SX, S_SY, S_FIN, S_DIV
   } state_type;

   state_type state_ff, div_ret_ff;

   logic                     glide_en_ff;
   logic [RATE_W-1:0]        rate_ff;
   logic [SR_W-1:0]          sr_ff;
   logic [LEN_CFG_W-1:0]     len_cfg_ff;

   logic [PW-1:0]            phase_ff;
   logic [FREQ_W-1:0]        cur_ff;
   logic                     started_ff;
   logic [TIME_W-1:0]        seg_time_ff;
   logic [LEVEL_W-1:0]       start_lvl_ff;
   logic [LEVEL_W-1:0]       end_lvl_ff;

   logic [FREQ_W-1:0]        tgt_ff;
   logic [TIME_W-1:0]        atk_ff;
   logic [TIME_W-1:0]        dec_ff;
   logic [LEVEL_W-1:0]       sus_ff;
   logic [LEVEL_W-1:0]       mx_ff;

   logic [DIV_N_W-1:0]       div_n_ff;
   logic [DIV_D_W-1:0]       div_r_ff;
   logic [DIV_D_W-1:0]       div_d_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;

   logic signed [2*MUL_W-1:0] mul_p_ff;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;

   logic [DIV_D_W-1:0]       stepm_ff;
   logic [15:0]              frac_ff;
   logic [AW-1:0]            i1_ff;
   logic [31:0]              v0_ff;
   logic [31:0]              v1_ff;
   logic                     env_atk_ff;
   logic [LEVEL_W-1:0]       amp_ff;
   logic [33:0]              acc_ff;
   logic signed [COORD_W-1:0] px_ff;
   logic signed [COORD_W-1:0] py_ff;
   logic [COORD_W-1:0]       ox_ff;
   logic [COORD_W-1:0]       oy_ff;
   logic                     rsp_valid_ff;
   logic [COORD_W-1:0]       rsp_x_ff;
   logic [COORD_W-1:0]       rsp_y_ff;

   logic [RATE_W-1:0]        rate_eff;
   logic [SR_W-1:0]          sr_eff;
   logic [LW-1:0]            len_eff;
   logic [DIV_D_W-1:0]       wrap;

   logic [DIV_D_W:0]         div_sh;
   logic [DIV_D_W:0]         div_sub;
   logic                     div_ge;

   logic [AW-1:0]            i0;
   logic [AW:0]              i0p1;
   logic [AW-1:0]            i1;
   logic [DIV_D_W:0]         ph_sum;
   logic [AW-1:0]            rd_addr;
   logic [31:0]              rd_data;
   logic                     wr_en;

   logic [LEVEL_W-1:0]       sus_sat;
   logic [LEVEL_W-1:0]       mx_sat;
   logic                     in_atk;
   logic                     in_dec;
   logic [TIME_W:0]          atk_dec;
   logic [LEVEL_W-1:0]       env_diff;
   logic [24:0]              gup_n;
   logic [FREQ_W-1:0]        gdn_q;
   logic [16:0]              one_m_frac;
   logic [33:0]              ip_sum;
   logic [2*MUL_W-1:0]       sc_sum;
   logic [LEVEL_W-1:0]       env_q;

   assign rate_eff = rate_ff[RATE_W-1] ? rate_ff : RATE_ONE;
   assign sr_eff = (sr_ff == '0) ? SR_W'(1) : sr_ff;

   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(len_cfg_ff) > MAX_VERTICES) begin
         len_eff = LW'(MAX_VERTICES);
      end else begin
         len_eff = LW'(len_cfg_ff);
      end
   end

   assign wrap = DIV_D_W'(len_eff) << 16;

   assign sus_sat = (req_sustain_level > LEVEL_ONE) ? LEVEL_ONE : req_sustain_level;
   assign mx_sat = (req_peak_level > LEVEL_ONE) ? LEVEL_ONE : req_peak_level;

   assign div_sh = {div_r_ff, div_n_ff[DIV_N_W-1]};
   assign div_sub = div_sh - {1'b0, div_d_ff};
   assign div_ge = div_sh >= {1'b0, div_d_ff};

   assign i0 = div_r_ff[AW+15:16];
   assign i0p1 = (AW+1)'(i0) + (AW+1)'(1);
   assign i1 = (i0p1 == (AW+1)'(len_eff)) ? '0 : i0p1[AW-1:0];
   assign ph_sum = {1'b0, div_r_ff} + {1'b0, stepm_ff};

   assign in_atk = seg_time_ff < atk_ff;
   assign atk_dec = {1'b0, atk_ff} + {1'b0, dec_ff};
   assign in_dec = {1'b0, seg_time_ff} < atk_dec;
   assign env_diff = (mx_ff >= start_lvl_ff) ? (mx_ff - start_lvl_ff)
                                             : (start_lvl_ff - mx_ff);
   assign env_q = div_n_ff[LEVEL_W-1:0];
   assign gup_n = mul_p_ff[40:16];
   assign gdn_q = div_n_ff[FREQ_W-1:0];
   assign one_m_frac = 17'h10000 - {1'b0, frac_ff};
   assign ip_sum = acc_ff + mul_p_ff[33:0] + 34'd32768;
   assign sc_sum = mul_p_ff + (2*MUL_W)'(16384);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ENDLVL: begin
            mul_a = MUL_W'(sus_ff);
            mul_b = MUL_W'(mx_ff);
         end
         S_GLIDE: begin
            mul_a = MUL_W'(cur_ff);
            mul_b = MUL_W'(rate_eff);
         end
         S_STEPMUL: begin
            mul_a = MUL_W'(len_eff);
            mul_b = MUL_W'(cur_ff);
         end
         S_ENV: begin
            if (in_atk) begin
               mul_a = MUL_W'(env_diff);
               mul_b = MUL_W'(seg_time_ff);
            end else begin
               mul_a = MUL_W'(mx_ff - sus_ff);
               mul_b = MUL_W'(seg_time_ff - atk_ff);
            end
         end
         S_IX0: begin
            mul_a = MUL_W'({~v0_ff[31], v0_ff[30:16]});
            mul_b = MUL_W'(one_m_frac);
         end
         S_IX1: begin
            mul_a = MUL_W'({~v1_ff[31], v1_ff[30:16]});
            mul_b = MUL_W'(frac_ff);
         end
         S_IX2: begin
            mul_a = MUL_W'({~v0_ff[15], v0_ff[14:0]});
            mul_b = MUL_W'(one_m_frac);
         end
         S_IY1: begin
            mul_a = MUL_W'({~v1_ff[15], v1_ff[14:0]});
            mul_b = MUL_W'(frac_ff);
         end
         S_IY2: begin
            mul_a = MUL_W'(px_ff);
            mul_b = MUL_W'(amp_ff);
         end
         S_SX: begin
            mul_a = MUL_W'(py_ff);
            mul_b = MUL_W'(amp_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign rd_addr = (state_ff == S_RD0) ? i0 : i1_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign wr_en = req_valid && req_ready && !req_mode
                  && (32'(req_vertex_index) < MAX_VERTICES);

   vwao_ram #(
      .WIDTH (32),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_vertex_index)),
      .wr_data ({req_vertex_x, req_vertex_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
      if (csr_valid) begin
         case (csr_index)
            CSR_GLIDE_ENABLE: glide_en_ff <= csr_data[0];
            CSR_GLIDE_RATE:   rate_ff <= csr_data[RATE_W-1:0];
            CSR_SAMPLE_RATE:  sr_ff <= csr_data[SR_W-1:0];
            CSR_IMAGE_LENGTH: len_cfg_ff <= csr_data[LEN_CFG_W-1:0];
            default: begin
            end
         endcase
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_mode) begin
               tgt_ff <= req_target_freq;
               atk_ff <= req_attack_len;
               dec_ff <= req_decay_len;
               sus_ff <= sus_sat;
               mx_ff <= mx_sat;
               if (req_segment_start) begin
                  seg_time_ff <= '0;
                  start_lvl_ff <= end_lvl_ff;
               end
               state_ff <= S_ENDLVL;
            end
         end
         S_ENDLVL: begin
            state_ff <= S_GLIDE;
         end
         S_GLIDE: begin
            end_lvl_ff <= LEVEL_W'((mul_p_ff[31:0] + 32'd16384) >> 15);
            started_ff <= 1'b1;
            if (!glide_en_ff || !started_ff) begin
               cur_ff <= tgt_ff;
               state_ff <= S_STEPMUL;
            end else if (cur_ff < tgt_ff) begin
               state_ff <= S_GUP;
            end else if (cur_ff > tgt_ff) begin
               div_n_ff <= DIV_N_W'({cur_ff, 16'h0000});
               div_d_ff <= DIV_D_W'(rate_eff);
               div_r_ff <= '0;
               div_cnt_ff <= DIV_CNT_W'(DIV_N_W - 1);
               div_ret_ff <= S_GDN;
               state_ff <= S_DIV;
            end else begin
               state_ff <= S_STEPMUL;
            end
         end
         S_GUP: begin
            if (gup_n <= {1'b0, cur_ff}) begin
               cur_ff <= ((cur_ff + FREQ_W'(1)) > tgt_ff) ? tgt_ff : cur_ff + FREQ_W'(1);
            end else begin
               cur_ff <= (gup_n > {1'b0, tgt_ff}) ? tgt_ff : gup_n[FREQ_W-1:0];
            end
            state_ff <= S_STEPMUL;
         end
         S_GDN: begin
            if (gdn_q >= cur_ff) begin
               cur_ff <= ((cur_ff - FREQ_W'(1)) < tgt_ff) ? tgt_ff : cur_ff - FREQ_W'(1);
            end else begin
               cur_ff <= (gdn_q < tgt_ff) ? tgt_ff : gdn_q;
            end
            state_ff <= S_STEPMUL;
         end
         S_STEPMUL: begin
            state_ff <= S_STEPDIV;
         end
         S_STEPDIV: begin
            div_n_ff <= DIV_N_W'({mul_p_ff[40:0], 6'b000000});
            div_d_ff <= DIV_D_W'(sr_eff);
            div_r_ff <= '0;
            div_cnt_ff <= DIV_CNT_W'(DIV_N_W - 1);
            div_ret_ff <= S_STEPMOD;
            state_ff <= S_DIV;
         end
         S_STEPMOD: begin
            div_d_ff <= wrap;
            div_r_ff <= '0;
            div_cnt_ff <= DIV_CNT_W'(DIV_N_W - 1);
            div_ret_ff <= S_PHMOD;
            state_ff <= S_DIV;
         end
         S_PHMOD: begin
            stepm_ff <= div_r_ff;
            div_n_ff <= DIV_N_W'(phase_ff);
            div_d_ff <= wrap;
            div_r_ff <= '0;
            div_cnt_ff <= DIV_CNT_W'(DIV_N_W - 1);
            div_ret_ff <= S_RD0;
            state_ff <= S_DIV;
         end
         S_RD0: begin
            frac_ff <= div_r_ff[15:0];
            i1_ff <= i1;
            if (ph_sum >= {1'b0, wrap}) begin
               phase_ff <= PW'(ph_sum - {1'b0, wrap});
            end else begin
               phase_ff <= PW'(ph_sum);
            end
            state_ff <= S_RD1;
         end
         S_RD1: begin
            v0_ff <= rd_data;
            state_ff <= S_RD2;
         end
         S_RD2: begin
            v1_ff <= rd_data;
            state_ff <= S_ENV;
         end
         S_ENV: begin
            if (in_atk) begin
               env_atk_ff <= 1'b1;
               state_ff <= S_ENVDIV;
            end else if (in_dec && (sus_ff < mx_ff)) begin
               env_atk_ff <= 1'b0;
               state_ff <= S_ENVDIV;
            end else begin
               amp_ff <= (in_dec || (mx_ff < sus_ff)) ? mx_ff : sus_ff;
               state_ff <= S_IX0;
            end
         end
         S_ENVDIV: begin
            div_n_ff <= DIV_N_W'(mul_p_ff[39:0]);
            div_d_ff <= DIV_D_W'(env_atk_ff ? atk_ff : dec_ff);
            div_r_ff <= '0;
            div_cnt_ff <= DIV_CNT_W'(DIV_N_W - 1);
            div_ret_ff <= S_ENVEND;
            state_ff <= S_DIV;
         end
         S_ENVEND: begin
            if (!env_atk_ff) begin
               amp_ff <= mx_ff - env_q;
            end else if (mx_ff >= start_lvl_ff) begin
               amp_ff <= start_lvl_ff + env_q;
            end else begin
               amp_ff <= start_lvl_ff - env_q;
            end
            state_ff <= S_IX0;
         end
         S_IX0: begin
            state_ff <= S_IX1;
         end
         S_IX1: begin
            acc_ff <= mul_p_ff[33:0];
            state_ff <= S_IX2;
         end
         S_IX2: begin
            px_ff <= {~ip_sum[31], ip_sum[30:16]};
            state_ff <= S_IY1;
         end
         S_IY1: begin
            acc_ff <= mul_p_ff[33:0];
            state_ff <= S_IY2;
         end
         S_IY2: begin
            py_ff <= {~ip_sum[31], ip_sum[30:16]};
            state_ff <= S_SX;
         end
         S_SX: begin
            ox_ff <= sc_sum[30:15];
            state_ff <= S_SY;
         end
         S_SY: begin
            oy_ff <= sc_sum[30:15];
            state_ff <= S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_x_ff <= ox_ff;
               rsp_y_ff <= oy_ff;
               if (seg_time_ff != {TIME_W{1'b1}}) begin
                  seg_time_ff <= seg_time_ff + TIME_W'(1);
               end
               state_ff <= S_IDLE;
            end
         end
         S_DIV: begin
            div_n_ff <= {div_n_ff[DIV_N_W-2:0], div_ge};
            div_r_ff <= div_ge ? div_sub[DIV_D_W-1:0] : div_sh[DIV_D_W-1:0];
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_ff <= div_ret_ff;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         div_ret_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         glide_en_ff <= 1'b1;
         rate_ff <= RATE_RESET;
         sr_ff <= SR_RESET;
         len_cfg_ff <= LEN_RESET;
         phase_ff <= '0;
         cur_ff <= '0;
         started_ff <= 1'b0;
         seg_time_ff <= '0;
         start_lvl_ff <= '0;
         end_lvl_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign csr_ready = 1'b1;

   `VWAO_ASSERT_NEXT(a_busy_after_sample, clock, reset, req_valid && req_ready && req_mode, !req_ready)
   `VWAO_ASSERT(a_phase_in_range, clock, reset, (state_ff != S_RD1) || (DIV_D_W'(phase_ff) < wrap))
   `VWAO_ASSERT(a_glide_down_bound, clock, reset, (state_ff != S_GDN) || (div_n_ff <= DIV_N_W'(cur_ff)))
   `VWAO_ASSERT(a_amp_bound, clock, reset, (state_ff != S_IX0) || (amp_ff <= LEVEL_ONE))
endmodule
`default_nettype wire
